/* hw/rtl/bws_pkg.sv */
// ============================================================================
// bws_pkg
// Shared types and constants for the boundary window smoother.
// ============================================================================
`default_nettype none

package bws_pkg;

   // Field widths
   localparam int BOUND_W     = 8;   // one boundary position, pixel index
   localparam int ENTRIES_W   = 5;   // reported pair count
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int RETAIN_W    = 4;

   // Default window storage depth
   localparam int DEF_WINDOW_DEPTH = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RETAIN_LIMIT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE    = 4'd1;

   // Register reset values
   localparam logic [RETAIN_W-1:0] RETAIN_RESET    = 4'd7;
   localparam logic [BOUND_W-1:0]  TOLERANCE_RESET = 8'd3;

   // Request type codes
   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

endpackage : bws_pkg

`default_nettype wire

/* hw/rtl/boundary_window_smoother_core.sv */
// ============================================================================
// boundary_window_smoother_core
// Sliding window over track-boundary pairs with mean, median and steady flags.
// ============================================================================
// Usage:
//   Request channel (req_*): one transaction per frame, either a boundary pair
//   push or a window clear. Taken when req_valid is high and req_stall low.
//   req_stall stays high while a transaction is being worked on.
//   Result channel (rsp_*): one transaction per request, held in an output
//   register until rsp_stall is low. A new request is taken while a result
//   still waits; the next result waits in the sequencer until the register
//   frees up.
//   Config channel (csr_*): retain_limit and tolerance, write only, always
//   ready; write only while the block is idle.
//   Sequence: a clear goes straight to the result stage. A push writes the
//   new pair, then the window memory is walked once for the sums and once per
//   result bit for the medians (one read port, one entry per cycle), then an
//   8-step shared divider forms both means.
//   One request is in work at a time.
//   Reset: window empty, retain_limit 7, tolerance 3. The pair memory is not
//   cleared; only held entries are ever read.
// ============================================================================
`default_nettype none

module boundary_window_smoother_core
   import bws_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   // request channel
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire                    req_type,
   input  wire [BOUND_W-1:0]      req_left_bound,
   input  wire [BOUND_W-1:0]      req_right_bound,
   // result channel
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [ENTRIES_W-1:0]   rsp_entries,
   output logic [BOUND_W-1:0]     rsp_mean_left,
   output logic [BOUND_W-1:0]     rsp_mean_right,
   output logic [BOUND_W-1:0]     rsp_median_left,
   output logic [BOUND_W-1:0]     rsp_median_right,
   output logic                   rsp_steady_left,
   output logic                   rsp_steady_right,
   // config channel
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int CW    = $clog2(WINDOW_DEPTH + 1);
   localparam int SW    = CW + BOUND_W;
   localparam int CMPW  = CW + RETAIN_W;
   localparam int PAIRW = 2 * BOUND_W;
   localparam int NPASS = BOUND_W + 1;   // one sum pass, one pass per median bit

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WRITE = 5'b00010,
      ST_PASS  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Control state
   state_type          state_ff, state_in;
   logic [CW-1:0]      held_ff, held_in;
   logic [AW-1:0]      oldest_ff, oldest_in;
   logic [3:0]         pass_ff, pass_in;
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic               issue_ff, issue_in;
   logic               clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RETAIN_W-1:0] retain_ff;
   logic [BOUND_W-1:0]  tol_ff;

   // Datapath registers
   logic [BOUND_W-1:0] new_l_ff, new_l_in;
   logic [BOUND_W-1:0] new_r_ff, new_r_in;
   logic [SW-1:0]      sum_l_ff, sum_l_in;
   logic [SW-1:0]      sum_r_ff, sum_r_in;
   logic [1:0][1:0][BOUND_W-1:0] srch_ff, srch_in;   // [side][rank]
   logic [1:0][1:0][CW-1:0]      cnt_ff, cnt_in;
   logic [PAIRW-1:0]   mem_q_ff;

   // Result register
   logic [ENTRIES_W-1:0] out_entries_ff, out_entries_in;
   logic [BOUND_W-1:0]   out_mean_l_ff, out_mean_l_in;
   logic [BOUND_W-1:0]   out_mean_r_ff, out_mean_r_in;
   logic [BOUND_W-1:0]   out_med_l_ff, out_med_l_in;
   logic [BOUND_W-1:0]   out_med_r_ff, out_med_r_in;
   logic                 out_std_l_ff, out_std_l_in;
   logic                 out_std_r_ff, out_std_r_in;

   // Pair memory
   logic [PAIRW-1:0]   pair_mem [WINDOW_DEPTH];
   logic [AW-1:0]      mem_addr;
   logic               mem_we;

   // Misc combinational
   logic               req_take;
   logic               drop_oldest;
   logic [CW-1:0]      addr_off;
   logic [AW+1:0]      addr_sum;
   logic               pass_done;
   logic [BOUND_W-1:0] bit_mask;
   logic [1:0][BOUND_W-1:0] rd_val;
   logic [1:0][CW-1:0]      rank_k;
   logic [BOUND_W:0]   med_sum_l, med_sum_r;
   logic [BOUND_W-1:0] dist_l, dist_r;
   logic               div_start, div_done;
   logic [BOUND_W-1:0] quot_l, quot_r;
   logic               out_free;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         retain_ff <= RETAIN_RESET;
         tol_ff    <= TOLERANCE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RETAIN_LIMIT: retain_ff <= csr_wdata[RETAIN_W-1:0];
            REG_TOLERANCE:    tol_ff    <= csr_wdata[BOUND_W-1:0];
            default: ;
         endcase
      end
   end

   // Drop the oldest pair when over the limit or when storage is full
   assign drop_oldest = (CMPW'(held_ff) > CMPW'(retain_ff)) ||
                        (held_ff >= CW'(WINDOW_DEPTH));

   // Shared circular address unit: write slot or walk offset
   assign addr_off = (state_ff == ST_WRITE) ? held_ff : rd_idx_ff;
   always_comb begin
      addr_sum = (AW+2)'(oldest_ff) + (AW+2)'(addr_off);
      if (addr_sum >= (AW+2)'(WINDOW_DEPTH)) begin
         addr_sum = addr_sum - (AW+2)'(WINDOW_DEPTH);
      end
      mem_addr = addr_sum[AW-1:0];
   end

   assign mem_we = (state_ff == ST_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pair_mem[mem_addr] <= {new_r_ff, new_l_ff};
      end
      mem_q_ff <= pair_mem[mem_addr];
   end

   // Walk bookkeeping
   assign pass_done = (rd_idx_ff == held_ff) && !issue_ff;
   assign bit_mask  = BOUND_W'({1'b1, {(BOUND_W-1){1'b0}}} >> (pass_ff - 4'd1));
   assign rd_val[0] = mem_q_ff[BOUND_W-1:0];
   assign rd_val[1] = mem_q_ff[PAIRW-1:BOUND_W];
   assign rank_k[0] = (held_ff - 1'b1) >> 1;
   assign rank_k[1] = held_ff >> 1;
   assign div_start = (state_ff == ST_PASS) && pass_done && (pass_ff == 4'(NPASS - 1));

   // Result forming
   assign med_sum_l = (BOUND_W+1)'(srch_ff[0][0]) + (BOUND_W+1)'(srch_ff[0][1]);
   assign med_sum_r = (BOUND_W+1)'(srch_ff[1][0]) + (BOUND_W+1)'(srch_ff[1][1]);
   assign dist_l = (new_l_ff >= quot_l) ? (new_l_ff - quot_l) : (quot_l - new_l_ff);
   assign dist_r = (new_r_ff >= quot_r) ? (new_r_ff - quot_r) : (quot_r - new_r_ff);

   bws_div #(
      .CNT_W (CW)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .sum_left   (sum_l_ff),
      .sum_right  (sum_r_ff),
      .count      (held_ff),
      .done       (div_done),
      .quot_left  (quot_l),
      .quot_right (quot_r)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      held_in        = held_ff;
      oldest_in      = oldest_ff;
      pass_in        = pass_ff;
      rd_idx_in      = rd_idx_ff;
      issue_in       = 1'b0;
      clr_in         = clr_ff;
      new_l_in       = new_l_ff;
      new_r_in       = new_r_ff;
      sum_l_in       = sum_l_ff;
      sum_r_in       = sum_r_ff;
      srch_in        = srch_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      out_entries_in = out_entries_ff;
      out_mean_l_in  = out_mean_l_ff;
      out_mean_r_in  = out_mean_r_ff;
      out_med_l_in   = out_med_l_ff;
      out_med_r_in   = out_med_r_ff;
      out_std_l_in   = out_std_l_ff;
      out_std_r_in   = out_std_r_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               new_l_in = req_left_bound;
               new_r_in = req_right_bound;
               if (req_type == REQ_CLEAR) begin
                  clr_in    = 1'b1;
                  held_in   = '0;
                  oldest_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  clr_in = 1'b0;
                  if (drop_oldest) begin
                     oldest_in = (oldest_ff == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                      : oldest_ff + 1'b1;
                     held_in   = held_ff - 1'b1;
                  end
                  state_in = ST_WRITE;
               end
            end
         end

         ST_WRITE: begin
            held_in   = held_ff + 1'b1;
            pass_in   = '0;
            rd_idx_in = '0;
            sum_l_in  = '0;
            sum_r_in  = '0;
            srch_in   = '0;
            cnt_in    = '0;
            state_in  = ST_PASS;
         end

         ST_PASS: begin
            // issue one read per cycle
            if (rd_idx_ff != held_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               issue_in  = 1'b1;
            end
            // consume the read issued last cycle
            if (issue_ff) begin
               if (pass_ff == '0) begin
                  sum_l_in = sum_l_ff + SW'(rd_val[0]);
                  sum_r_in = sum_r_ff + SW'(rd_val[1]);
               end else begin
                  for (int s = 0; s < 2; s++) begin
                     for (int r = 0; r < 2; r++) begin
                        if (rd_val[s] < (srch_ff[s][r] | bit_mask)) begin
                           cnt_in[s][r] = cnt_ff[s][r] + 1'b1;
                        end
                     end
                  end
               end
            end
            // end of a pass: settle one median bit per search
            if (pass_done) begin
               if (pass_ff != '0) begin
                  for (int s = 0; s < 2; s++) begin
                     for (int r = 0; r < 2; r++) begin
                        if (cnt_ff[s][r] <= rank_k[r]) begin
                           srch_in[s][r] = srch_ff[s][r] | bit_mask;
                        end
                     end
                  end
               end
               cnt_in    = '0;
               rd_idx_in = '0;
               pass_in   = pass_ff + 1'b1;
               if (pass_ff == 4'(NPASS - 1)) begin
                  state_in = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (clr_ff) begin
                  out_entries_in = '0;
                  out_mean_l_in  = '0;
                  out_mean_r_in  = '0;
                  out_med_l_in   = '0;
                  out_med_r_in   = '0;
                  out_std_l_in   = 1'b0;
                  out_std_r_in   = 1'b0;
               end else begin
                  out_entries_in = ENTRIES_W'(held_ff);
                  out_mean_l_in  = quot_l;
                  out_mean_r_in  = quot_r;
                  out_med_l_in   = med_sum_l[BOUND_W:1];
                  out_med_r_in   = med_sum_r[BOUND_W:1];
                  out_std_l_in   = (dist_l <= tol_ff);
                  out_std_r_in   = (dist_r <= tol_ff);
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         oldest_ff    <= '0;
         pass_ff      <= '0;
         rd_idx_ff    <= '0;
         issue_ff     <= 1'b0;
         clr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         oldest_ff    <= oldest_in;
         pass_ff      <= pass_in;
         rd_idx_ff    <= rd_idx_in;
         issue_ff     <= issue_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_l_ff       <= new_l_in;
      new_r_ff       <= new_r_in;
      sum_l_ff       <= sum_l_in;
      sum_r_ff       <= sum_r_in;
      srch_ff        <= srch_in;
      cnt_ff         <= cnt_in;
      out_entries_ff <= out_entries_in;
      out_mean_l_ff  <= out_mean_l_in;
      out_mean_r_ff  <= out_mean_r_in;
      out_med_l_ff   <= out_med_l_in;
      out_med_r_ff   <= out_med_r_in;
      out_std_l_ff   <= out_std_l_in;
      out_std_r_ff   <= out_std_r_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entries      = out_entries_ff;
   assign rsp_mean_left    = out_mean_l_ff;
   assign rsp_mean_right   = out_mean_r_ff;
   assign rsp_median_left  = out_med_l_ff;
   assign rsp_median_right = out_med_r_ff;
   assign rsp_steady_left  = out_std_l_ff;
   assign rsp_steady_right = out_std_r_ff;

endmodule : boundary_window_smoother_core

`default_nettype wire

/* hw/rtl/bws_div.sv */
// ============================================================================
// bws_div
// Two-lane restoring divider: left and right sums over one shared count,
// one quotient bit per cycle. The quotient is known to fit in BOUND_W bits.
// ============================================================================
`default_nettype none

module bws_div
   import bws_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire [CNT_W+BOUND_W-1:0]  sum_left,
   input  wire [CNT_W+BOUND_W-1:0]  sum_right,
   input  wire [CNT_W-1:0]          count,
   output logic                     done,
   output logic [BOUND_W-1:0]       quot_left,
   output logic [BOUND_W-1:0]       quot_right
);

   localparam int SUM_W  = CNT_W + BOUND_W;
   localparam int STEP_W = $clog2(BOUND_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    rem_l_ff, rem_l_in;
   logic [SUM_W-1:0]    rem_r_ff, rem_r_in;
   logic [SUM_W-1:0]    dvs_ff, dvs_in;
   logic [BOUND_W-1:0]  q_l_ff, q_l_in;
   logic [BOUND_W-1:0]  q_r_ff, q_r_in;

   // One compare/subtract step per lane
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_l_in = rem_l_ff;
      rem_r_in = rem_r_ff;
      dvs_in   = dvs_ff;
      q_l_in   = q_l_ff;
      q_r_in   = q_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_l_in = sum_left;
         rem_r_in = sum_right;
         dvs_in   = SUM_W'(count) << (BOUND_W - 1);
      end else if (busy_ff) begin
         if (rem_l_ff >= dvs_ff) begin
            rem_l_in = rem_l_ff - dvs_ff;
         end
         if (rem_r_ff >= dvs_ff) begin
            rem_r_in = rem_r_ff - dvs_ff;
         end
         q_l_in  = {q_l_ff[BOUND_W-2:0], (rem_l_ff >= dvs_ff)};
         q_r_in  = {q_r_ff[BOUND_W-2:0], (rem_r_ff >= dvs_ff)};
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(BOUND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_l_ff <= rem_l_in;
      rem_r_ff <= rem_r_in;
      dvs_ff   <= dvs_in;
      q_l_ff   <= q_l_in;
      q_r_ff   <= q_r_in;
   end

   assign done       = done_ff;
   assign quot_left  = q_l_ff;
   assign quot_right = q_r_ff;

endmodule : bws_div

`default_nettype wire
